@@ rtl/jcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jcs_pkg;

    // Characters the lexer reacts to
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChNl     = 8'h0A;

    // Command queue between front and back
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } lex_mode_t;

    // One accepted byte turns into up to three output beats, always in this
    // order: a held slash, the byte itself, the terminator.
    typedef struct packed {
        logic       lead_slash;
        logic       byte_valid;
        logic [7:0] byte_val;
        logic       term;
    } jcs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

@@ rtl/jcs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jcs_front
    import jcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    output jcs_cmd_t          cmd,
    output logic              push,
    input  fifo_status_t      fifo_st
);

    lex_mode_t mode_reg, mode_next;
    logic      esc_reg, esc_next;
    logic      slash_reg, slash_next;
    logic      star_reg, star_next;
    logic      accept;
    logic      lead;
    logic      byte_v;
    logic      term;

    assign s_tready = !fifo_st.full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            esc_reg   <= 1'b0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        lead       = 1'b0;
        byte_v     = 1'b0;
        term       = 1'b0;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (slash_reg && s_tdata == ChSlash)
                begin
                    slash_next = 1'b0;
                    mode_next  = MODE_LINE;
                end
                else if (slash_reg && s_tdata == ChStar)
                begin
                    slash_next = 1'b0;
                    mode_next  = MODE_BLOCK;
                    star_next  = 1'b0;
                end
                else
                begin
                    lead       = slash_reg;
                    slash_next = 1'b0;
                    if (s_tdata == ChQuote)
                    begin
                        mode_next = MODE_STRING;
                        byte_v    = 1'b1;
                    end
                    else if (s_tdata == ChSlash)
                    begin
                        slash_next = 1'b1;
                    end
                    else
                    begin
                        byte_v = 1'b1;
                    end
                end
            end
            MODE_STRING:
            begin
                byte_v = 1'b1;
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                end
                else if (s_tdata == ChBslash)
                begin
                    esc_next = 1'b1;
                end
                else if (s_tdata == ChQuote)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_LINE:
            begin
                if (s_tdata == ChNl)
                begin
                    mode_next = MODE_NORMAL;
                    byte_v    = 1'b1;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && s_tdata == ChSlash)
                begin
                    mode_next = MODE_NORMAL;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (s_tdata == ChStar);
                end
            end
        endcase

        // End of text: a freshly held slash goes out as the byte itself
        // (the byte is that slash), then the terminator; drop all state.
        if (s_tlast)
        begin
            byte_v     = byte_v | slash_next;
            term       = 1'b1;
            mode_next  = MODE_NORMAL;
            esc_next   = 1'b0;
            slash_next = 1'b0;
            star_next  = 1'b0;
        end
    end

    assign cmd.lead_slash = lead;
    assign cmd.byte_valid = byte_v;
    assign cmd.byte_val   = s_tdata;
    assign cmd.term       = term;
    assign push           = accept && (lead || byte_v || term);

    a_slash_only_normal: assert property (@(posedge clk) disable iff (!rst_n)
        slash_reg |-> (mode_reg == MODE_NORMAL))
        else $error("slash held outside normal text");

endmodule

`default_nettype wire

@@ rtl/jcs_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jcs_fifo
    import jcs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  jcs_cmd_t     wr_cmd,
    input  wire logic    pop,
    output jcs_cmd_t     rd_cmd,
    output fifo_status_t st
);

    jcs_cmd_t                    mem_reg [FifoDepth];
    logic     [FifoPtrW-1:0]     wr_ptr_reg;
    logic     [FifoPtrW-1:0]     rd_ptr_reg;
    logic     [FifoCntW-1:0]     cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign st.full  = (cnt_reg == FifoCntW'(FifoDepth));
    assign st.empty = (cnt_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        st.full |-> !push)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        st.empty |-> !pop)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

@@ rtl/jcs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jcs_back
    import jcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  jcs_cmd_t         head_cmd,
    input  fifo_status_t     fifo_st,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    jcs_cmd_t   cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_term_reg, out_term_next;
    logic       out_last_reg, out_last_next;
    jcs_cmd_t   src;
    jcs_cmd_t   rest;
    logic       src_valid;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign src       = cur_valid_reg ? cur_reg : head_cmd;
    assign src_valid = cur_valid_reg || !fifo_st.empty;

    always_comb
    begin
        rest           = src;
        out_byte_next  = out_byte_reg;
        out_term_next  = out_term_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pop            = 1'b0;

        // Peel off the first pending beat of the command
        if (src.lead_slash)
        begin
            out_byte_next   = ChSlash;
            out_term_next   = 1'b0;
            rest.lead_slash = 1'b0;
        end
        else if (src.byte_valid)
        begin
            out_byte_next   = src.byte_val;
            out_term_next   = 1'b0;
            rest.byte_valid = 1'b0;
        end
        else
        begin
            out_byte_next = 8'h00;
            out_term_next = 1'b1;
            rest.term     = 1'b0;
        end
        out_last_next = !(rest.lead_slash || rest.byte_valid || rest.term);

        if (slot_free && src_valid)
        begin
            out_valid_next = 1'b1;
            pop            = !cur_valid_reg;
            cur_next       = rest;
            cur_valid_next = !out_last_next;
        end
        else
        begin
            out_byte_next = out_byte_reg;
            out_term_next = out_term_reg;
            out_last_next = out_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_term_reg <= out_term_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_term_reg;
    assign m_tlast  = out_last_reg;

    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
        else $error("terminator beat not last or not zero");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> !pop)
        else $error("queue popped while a command is still in progress");

endmodule

`default_nettype wire

@@ rtl/json_comment_stripper_top.sv @@
// Path: an accepted byte is written into the command queue at the edge that accepts it,
// and its first beat is then loaded from the queue into the output register, which
// offers it. Beats still queued ahead of it and a stalled output add their wait.
// Throughput: one byte per cycle in while the queue is not full, and one beat per cycle
// out while m_tready is high; a byte that yields two or three beats sends them one after
// another, and the 4-entry queue absorbs the burst. Comment bytes yield no beat.
// Reset (rst_n low, asynchronous): lexer back to normal text, queue empty, no beat.
`timescale 1ns / 1ps
`default_nettype none

module json_comment_stripper_top
    import jcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input stream: one text byte per beat
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // text_end
    // Output stream: kept bytes, then the terminator beat
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tuser,    // is_terminator
    output logic            m_tlast     // last beat caused by one input byte
);

    jcs_cmd_t     fr_cmd;
    jcs_cmd_t     head_cmd;
    logic         push;
    logic         pop;
    fifo_status_t fifo_st;

    // Front: lexer state machine, turns each byte into at most one command
    jcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (fr_cmd),
        .push     (push),
        .fifo_st  (fifo_st)
    );

    // Decouple lexer from output so either side can stall on its own
    jcs_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (fr_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .st     (fifo_st)
    );

    // Back: expand each command into its beats, one per cycle while m_tready is high
    jcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .fifo_st  (fifo_st),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/json_comment_stripper_top_tb.sv @@
`timescale 1ns / 1ps

module json_comment_stripper_top_tb;
    import jcs_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandItems  = 150;
    localparam int DirRows    = 26;

    // One output beat: kept byte, terminator flag, last beat of the input byte
    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       last;
    } beat_t;

    // One stimulus row. With typed set, n kept bytes e0..e2 are expected,
    // followed by the terminator when fin is set; otherwise the stripper
    // model below decides.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } row_t;

    typedef enum {
        TK_PLAIN,
        TK_STRING,
        TK_LINE,
        TK_BLOCK,
        TK_SLASH,
        TK_SPECIAL
    } token_kind_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    row_t       drv_row = '0;
    int         send_idle = 14;
    int         recv_idle = 60;
    int         cycles    = 0;
    int         err_count = 0;

    // Stripper model state
    lex_mode_t  lex_mode   = MODE_NORMAL;
    logic       esc_pend   = 1'b0;
    logic       slash_pend = 1'b0;
    logic       star_prev  = 1'b0;

    beat_t      step_beats[$];
    beat_t      kept_beats[$];
    row_t       dir_rows[DirRows];
    row_t       rand_text[$];

    json_comment_stripper_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void keep_byte(input logic [7:0] c, input logic term);
        beat_t b;
        b.data = c;
        b.term = term;
        b.last = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void normal_text_byte(input logic [7:0] c);
        if (c == ChQuote)
        begin
            lex_mode = MODE_STRING;
            keep_byte(c, 1'b0);
        end
        else if (c == ChSlash)
            slash_pend = 1'b1;
        else
            keep_byte(c, 1'b0);
    endfunction

    // Advance the stripper by one byte; leave its beats in step_beats
    function automatic void strip_byte(input logic [7:0] c, input logic fin);
        beat_t b;
        step_beats.delete();
        case (lex_mode)
            MODE_NORMAL:
            begin
                if (slash_pend)
                begin
                    slash_pend = 1'b0;
                    if (c == ChSlash)
                        lex_mode = MODE_LINE;
                    else if (c == ChStar)
                    begin
                        lex_mode  = MODE_BLOCK;
                        star_prev = 1'b0;
                    end
                    else
                    begin
                        keep_byte(ChSlash, 1'b0);
                        normal_text_byte(c);
                    end
                end
                else
                    normal_text_byte(c);
            end
            MODE_STRING:
            begin
                keep_byte(c, 1'b0);
                if (esc_pend)
                    esc_pend = 1'b0;
                else if (c == ChBslash)
                    esc_pend = 1'b1;
                else if (c == ChQuote)
                    lex_mode = MODE_NORMAL;
            end
            MODE_LINE:
            begin
                if (c == ChNl)
                begin
                    lex_mode = MODE_NORMAL;
                    keep_byte(c, 1'b0);
                end
            end
            default:
            begin
                // the opening star never counts toward the closing pair
                if (star_prev && c == ChSlash)
                begin
                    lex_mode  = MODE_NORMAL;
                    star_prev = 1'b0;
                end
                else
                    star_prev = (c == ChStar);
            end
        endcase
        if (fin)
        begin
            if (slash_pend)
                keep_byte(ChSlash, 1'b0);
            keep_byte(8'h00, 1'b1);
            lex_mode   = MODE_NORMAL;
            esc_pend   = 1'b0;
            slash_pend = 1'b0;
            star_prev  = 1'b0;
        end
        if (step_beats.size() > 0)
        begin
            b = step_beats[step_beats.size() - 1];
            b.last = 1'b1;
            step_beats[step_beats.size() - 1] = b;
        end
    endfunction

    // Replace the modeled beats with the ones typed into the row
    function automatic void take_typed_beats(input row_t r);
        beat_t b;
        step_beats.delete();
        for (int k = 0; k < r.n; k++)
        begin
            b.data = (k == 0) ? r.e0 : (k == 1) ? r.e1 : r.e2;
            b.term = 1'b0;
            b.last = 1'b0;
            step_beats.push_back(b);
        end
        if (r.fin)
        begin
            b.data = 8'h00;
            b.term = 1'b1;
            b.last = 1'b0;
            step_beats.push_back(b);
        end
        if (step_beats.size() > 0)
        begin
            b = step_beats[step_beats.size() - 1];
            b.last = 1'b1;
            step_beats[step_beats.size() - 1] = b;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    // Input acceptance feeds the model; output beats are checked in order
    always @(posedge clk)
    begin : scoreboard
        beat_t want;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                strip_byte(s_tdata, s_tlast);
                if (drv_row.typed)
                    take_typed_beats(drv_row);
                foreach (step_beats[k])
                    kept_beats.push_back(step_beats[k]);
            end
            if (m_tvalid && m_tready)
            begin
                if (kept_beats.size() == 0)
                    report_mismatch($sformatf("unexpected beat data %02h user %b last %b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    want = kept_beats.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  m_tdata, want.data));
                    if (m_tuser !== want.term)
                        report_mismatch($sformatf("is_terminator %b, want %b",
                                                  m_tuser, want.term));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  m_tlast, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    // Present one byte after a random gap; hold it until accepted
    task automatic send_byte(input row_t r);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tlast  <= r.fin;
        drv_row  <= r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic void push_text(input logic [7:0] c);
        row_t r;
        r = '0;
        r.data = c;
        rand_text.push_back(r);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one lexical token: mostly well-formed strings and comments
    function automatic void gen_token();
        int len;
        len = $urandom_range(0, 6);
        case (token_kind_t'($urandom_range(0, 5)))
            TK_PLAIN:
                for (int k = 0; k <= len; k++)
                    push_text(any_byte());
            TK_STRING:
            begin
                push_text(ChQuote);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        push_text(ChBslash);
                        push_text($urandom_range(0, 1) ? ChQuote : any_byte());
                    end
                    else
                        push_text(any_byte());
                end
                if ($urandom_range(0, 7) != 0)
                    push_text(ChQuote);
            end
            TK_LINE:
            begin
                push_text(ChSlash);
                push_text(ChSlash);
                for (int k = 0; k < len; k++)
                    push_text($urandom_range(0, 3) == 0 ? ChStar : any_byte());
                if ($urandom_range(0, 7) != 0)
                    push_text(ChNl);
            end
            TK_BLOCK:
            begin
                push_text(ChSlash);
                push_text(ChStar);
                for (int k = 0; k < len; k++)
                    push_text($urandom_range(0, 2) == 0 ? ChStar : any_byte());
                if ($urandom_range(0, 7) != 0)
                begin
                    push_text(ChStar);
                    push_text(ChSlash);
                end
            end
            TK_SLASH:
            begin
                push_text(ChSlash);
                push_text(any_byte());
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: push_text(ChQuote);
                    1: push_text(ChSlash);
                    2: push_text(ChStar);
                    3: push_text(ChBslash);
                    default: push_text(ChNl);
                endcase
            end
        endcase
    endfunction

    function automatic void end_text_here();
        row_t r;
        r = rand_text[rand_text.size() - 1];
        r.fin = 1'b1;
        rand_text[rand_text.size() - 1] = r;
    endfunction

    initial
    begin : stimulus
        int total;
        dir_rows = '{
            // after reset, value extremes and the zero byte: copied as is
            '{8'h61,   1'b0, 1'b1, 2'd1, 8'h61,   8'h00, 8'h00},
            '{8'h01,   1'b0, 1'b1, 2'd1, 8'h01,   8'h00, 8'h00},
            '{8'hFF,   1'b0, 1'b1, 2'd1, 8'hFF,   8'h00, 8'h00},
            '{8'h00,   1'b0, 1'b1, 2'd1, 8'h00,   8'h00, 8'h00},
            // held slash released by a plain byte
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{8'h78,   1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            // string with a slash and an escaped quote
            '{ChQuote, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChBslash,1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChQuote, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChQuote, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            // line comment closed by a kept newline
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{8'h7A,   1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChNl,    1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            // block comment: slash star slash stays open
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChStar,  1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChStar,  1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChSlash, 1'b0, 1'b0, 2'd0, 8'h00,   8'h00, 8'h00},
            // slash on the final byte comes out ahead of the terminator
            '{ChSlash, 1'b1, 1'b1, 2'd1, ChSlash, 8'h00, 8'h00},
            // held slash plus byte plus terminator: three beats
            '{ChSlash, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00, 8'h00},
            '{8'h71,   1'b1, 1'b1, 2'd2, ChSlash, 8'h71, 8'h00},
            // unclosed block comment at the end: terminator only
            '{ChSlash, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChStar,  1'b0, 1'b1, 2'd0, 8'h00,   8'h00, 8'h00},
            '{ChStar,  1'b1, 1'b1, 2'd0, 8'h00,   8'h00, 8'h00}
        };

        while (rand_text.size() < RandItems)
        begin
            gen_token();
            if ($urandom_range(0, 5) == 0)
                end_text_here();
        end
        end_text_here();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i]);

        // Three pressure phases: slow receiver, slow sender, then full rate
        total = rand_text.size();
        foreach (rand_text[i])
        begin
            if (i == total / 3)
            begin
                send_idle = 60;
                recv_idle = 14;
            end
            else if (i == 2 * total / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_byte(rand_text[i]);
        end
        s_tvalid <= 1'b0;

        while (kept_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
